// ===== sv/spsn_pkg.sv =====
// Shared types, constants and step functions of the sphere pair separation pipeline.
`default_nettype none
package spsn_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int SEP_W   = 35;
    localparam int NORM_W  = 32;
    localparam int SQ_W    = 66;
    localparam int ROOT_W  = 33;
    localparam int REM_W   = 35;
    localparam int QUO_W   = 31;
    localparam int NUM_W   = 64;
    localparam int SQ_STEPS = 33;
    localparam int DV_STEPS = 31;
    localparam int FRAC_Q30 = 30;

    typedef struct packed {
        logic                         coinc;
        logic [2:0]                   neg;
        logic [2:0][COORD_W-1:0]      sh;
        logic [COORD_W-1:0]           rsum;
    } side_t;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][QUO_W-1:0] q;
        logic [ROOT_W-1:0]     den;
        logic [SEP_W-1:0]      sep;
        logic [2:0]            neg;
        logic                  coinc;
    } div_t;

    function automatic sqrt_lane_t sqrt_step(sqrt_lane_t a);
        sqrt_lane_t r;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        cur   = {a.rem[REM_W-3:0], a.rad[SQ_W-1:SQ_W-2]};
        trial = {a.root[ROOT_W-1:0], 2'b01};
        r.rad = {a.rad[SQ_W-3:0], 2'b00};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_t div_step(div_t a, int j);
        div_t r;
        logic [NUM_W-1:0] cmp;
        r   = a;
        cmp = {{(NUM_W-ROOT_W){1'b0}}, a.den} << j;
        for (int l = 0; l < 3; l++) begin
            if (a.rem[l] >= cmp) begin
                r.rem[l]  = a.rem[l] - cmp;
                r.q[l][j] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] lead_zeros(logic [COORD_W-1:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < COORD_W; i++) begin
            if (v[i]) begin
                n = 5'(COORD_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== sv/spsn_front.sv =====
// Front stages: axis differences, normalizing shift, squares and sums of squares.
`default_nettype none
module spsn_front
    import spsn_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [2:0][COORD_W-1:0]    left_c,
    input  wire logic [2:0][COORD_W-1:0]    right_c,
    input  wire logic [RAD_W-1:0]           left_rad,
    input  wire logic [RAD_W-1:0]           right_rad,
    output logic                            out_valid,
    output logic [SQ_W-1:0]                 out_s,
    output logic [SQ_W-1:0]                 out_sp,
    output side_t                           out_side
);

    logic [3:0]                vld_reg;
    logic [2:0][COORD_W-1:0]   mag_a_reg;
    logic [2:0]                neg_a_reg;
    logic [COORD_W-1:0]        rsum_a_reg;
    logic [2:0][COORD_W-1:0]   mag_b_reg;
    side_t                     side_b_reg;
    logic [2:0][63:0]          sqm_c_reg;
    logic [2:0][63:0]          sqs_c_reg;
    side_t                     side_c_reg;
    logic [SQ_W-1:0]           s_d_reg;
    logic [SQ_W-1:0]           sp_d_reg;
    side_t                     side_d_reg;

    logic [2:0][COORD_W:0]     diff;
    logic [2:0][COORD_W:0]     negd;
    logic [COORD_W-1:0]        mag_or;
    logic [4:0]                shift;
    side_t                     side_b_next;

    always_comb
    begin
        for (int l = 0; l < 3; l++) begin
            diff[l] = {right_c[l][COORD_W-1], right_c[l]} - {left_c[l][COORD_W-1], left_c[l]};
            negd[l] = -diff[l];
        end
        mag_or = mag_a_reg[0] | mag_a_reg[1] | mag_a_reg[2];
        shift  = lead_zeros(mag_or);
        side_b_next.coinc = (mag_or == '0);
        side_b_next.neg   = neg_a_reg;
        side_b_next.rsum  = rsum_a_reg;
        for (int l = 0; l < 3; l++) begin
            side_b_next.sh[l] = mag_a_reg[l] << shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                neg_a_reg[l] <= diff[l][COORD_W];
                mag_a_reg[l] <= diff[l][COORD_W] ? negd[l][COORD_W-1:0] : diff[l][COORD_W-1:0];
                mag_b_reg[l] <= mag_a_reg[l];
                sqm_c_reg[l] <= 64'(mag_b_reg[l]) * 64'(mag_b_reg[l]);
                sqs_c_reg[l] <= 64'(side_b_reg.sh[l]) * 64'(side_b_reg.sh[l]);
            end
            rsum_a_reg <= COORD_W'(left_rad) + COORD_W'(right_rad);
            side_b_reg <= side_b_next;
            side_c_reg <= side_b_reg;
            s_d_reg    <= SQ_W'(sqm_c_reg[0]) + SQ_W'(sqm_c_reg[1]) + SQ_W'(sqm_c_reg[2]);
            sp_d_reg   <= SQ_W'(sqs_c_reg[0]) + SQ_W'(sqs_c_reg[1]) + SQ_W'(sqs_c_reg[2]);
            side_d_reg <= side_c_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_s     = s_d_reg;
    assign out_sp    = sp_d_reg;
    assign out_side  = side_d_reg;

endmodule
`default_nettype wire

// ===== sv/spsn_sqrt.sv =====
// Two-lane pipelined square root, one root bit per stage.
`default_nettype none
module spsn_sqrt
    import spsn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [SQ_W-1:0]  in_s,
    input  wire logic [SQ_W-1:0]  in_sp,
    input  wire side_t            in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root_s,
    output logic [REM_W-1:0]      out_rem_s,
    output logic [ROOT_W-1:0]     out_root_sp,
    output side_t                 out_side
);

    logic [SQ_STEPS-1:0] vld_reg;
    sqrt_lane_t          s_reg    [SQ_STEPS];
    sqrt_lane_t          p_reg    [SQ_STEPS];
    side_t               side_reg [SQ_STEPS];
    sqrt_lane_t          init_s;
    sqrt_lane_t          init_p;

    always_comb
    begin
        init_s.rad  = in_s;
        init_s.rem  = '0;
        init_s.root = '0;
        init_p.rad  = in_sp;
        init_p.rem  = '0;
        init_p.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQ_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s_reg[0]    <= sqrt_step(init_s);
            p_reg[0]    <= sqrt_step(init_p);
            side_reg[0] <= in_side;
            for (int i = 1; i < SQ_STEPS; i++) begin
                s_reg[i]    <= sqrt_step(s_reg[i-1]);
                p_reg[i]    <= sqrt_step(p_reg[i-1]);
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid   = vld_reg[SQ_STEPS-1];
    assign out_root_s  = s_reg[SQ_STEPS-1].root;
    assign out_rem_s   = s_reg[SQ_STEPS-1].rem;
    assign out_root_sp = p_reg[SQ_STEPS-1].root;
    assign out_side    = side_reg[SQ_STEPS-1];

endmodule
`default_nettype wire

// ===== sv/spsn_div.sv =====
// Rounding of the distance and three-lane pipelined restoring divider for the normal.
`default_nettype none
module spsn_div
    import spsn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [ROOT_W-1:0] root_s,
    input  wire logic [REM_W-1:0]  rem_s,
    input  wire logic [ROOT_W-1:0] root_sp,
    input  wire side_t             in_side,
    output logic                   out_valid,
    output div_t                   out_res
);

    logic [DV_STEPS:0] vld_reg;
    div_t              d_reg [DV_STEPS+1];
    div_t              init_d;
    logic [ROOT_W:0]   dist_rnd;

    always_comb
    begin
        dist_rnd = {1'b0, root_s} + ((REM_W'(root_s) < rem_s) ? (ROOT_W+1)'(1) : '0);
        init_d.den   = root_sp;
        init_d.sep   = SEP_W'(dist_rnd) - SEP_W'(in_side.rsum);
        init_d.neg   = in_side.neg;
        init_d.coinc = in_side.coinc;
        for (int l = 0; l < 3; l++) begin
            init_d.rem[l] = ({32'd0, in_side.sh[l]} << FRAC_Q30) + NUM_W'(root_sp >> 1);
            init_d.q[l]   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DV_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            d_reg[0] <= init_d;
            for (int i = 1; i <= DV_STEPS; i++) begin
                d_reg[i] <= div_step(d_reg[i-1], DV_STEPS - i);
            end
        end
    end

    assign out_valid = vld_reg[DV_STEPS];
    assign out_res   = d_reg[DV_STEPS];

endmodule
`default_nettype wire

// ===== sv/sphere_pair_separation_normal.sv =====
// Top level of the sphere pair separation and contact normal pipeline.
// Throughput is one item per cycle; the 33-stage square root and the 31-stage divider
// each retire one bit per stage, and the whole pipeline advances unless a result stalls.
// Reset clears every valid bit; payload registers are not reset.
`default_nettype none
module sphere_pair_separation_normal
    import spsn_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // left_x, left_y, left_z, right_x, right_y, right_z, left_radius, right_radius
    input  wire logic [255:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // separation, normal_x, normal_y, normal_z
    output logic [135:0]      m_tdata,
    // coincident
    output logic              m_tuser
);

    logic                      en;
    logic [2:0][COORD_W-1:0]   left_c;
    logic [2:0][COORD_W-1:0]   right_c;
    logic                      f_valid;
    logic [SQ_W-1:0]           f_s;
    logic [SQ_W-1:0]           f_sp;
    side_t                     f_side;
    logic                      q_valid;
    logic [ROOT_W-1:0]         q_root_s;
    logic [REM_W-1:0]          q_rem_s;
    logic [ROOT_W-1:0]         q_root_sp;
    side_t                     q_side;
    logic                      d_valid;
    div_t                      d_res;
    logic [2:0][NORM_W-1:0]    norm_next;
    logic                      out_valid_reg;
    logic [SEP_W-1:0]          sep_reg;
    logic [2:0][NORM_W-1:0]    norm_reg;
    logic                      coinc_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int l = 0; l < 3; l++) begin
            left_c[l]  = s_tdata[l*COORD_W +: COORD_W];
            right_c[l] = s_tdata[(l+3)*COORD_W +: COORD_W];
            if (d_res.coinc) begin
                norm_next[l] = '0;
            end else if (d_res.neg[l]) begin
                norm_next[l] = -{1'b0, d_res.q[l]};
            end else begin
                norm_next[l] = {1'b0, d_res.q[l]};
            end
        end
    end

    spsn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .left_c    (left_c),
        .right_c   (right_c),
        .left_rad  (s_tdata[222:192]),
        .right_rad (s_tdata[253:223]),
        .out_valid (f_valid),
        .out_s     (f_s),
        .out_sp    (f_sp),
        .out_side  (f_side)
    );

    spsn_sqrt u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (f_valid),
        .in_s        (f_s),
        .in_sp       (f_sp),
        .in_side     (f_side),
        .out_valid   (q_valid),
        .out_root_s  (q_root_s),
        .out_rem_s   (q_rem_s),
        .out_root_sp (q_root_sp),
        .out_side    (q_side)
    );

    spsn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .root_s    (q_root_s),
        .rem_s     (q_rem_s),
        .root_sp   (q_root_sp),
        .in_side   (q_side),
        .out_valid (d_valid),
        .out_res   (d_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            sep_reg   <= d_res.sep;
            norm_reg  <= norm_next;
            coinc_reg <= d_res.coinc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, norm_reg[2], norm_reg[1], norm_reg[0], sep_reg};
    assign m_tuser  = coinc_reg;

    a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (norm_reg == '0))
        else $error("coincident result carries a nonzero normal");

    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (norm_reg != '0))
        else $error("separated centers gave a zero normal");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(norm_reg[0]) <= 32'sd1073741824
                      && $signed(norm_reg[0]) >= -32'sd1073741824))
        else $error("normal x component exceeds one");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!out_valid_reg || m_tready))
        else $error("input ready does not follow the pipeline advance");

endmodule
`default_nettype wire

// ===== dv/sphere_pair_separation_normal_tb.sv =====
// Self-checking testbench for the sphere pair separation and contact normal pipeline.
`default_nettype none
module sphere_pair_separation_normal_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spsn_pkg::*;

    typedef struct packed {
        logic [SEP_W-1:0]  sep;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
        logic              coinc;
    } contact_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tuser;

    logic [255:0] pending_pairs[$];
    contact_t     expected_contacts[$];
    int           mismatches = 0;
    int           pairs_sent = 0;
    int           contacts_seen = 0;
    int           coincident_seen = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    bit           calm_send = 1'b0;
    bit           calm_recv = 1'b0;

    sphere_pair_separation_normal uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    function automatic void int_sqrt(input logic [67:0] n, output logic [34:0] root,
                                     output logic [34:0] rest);
        logic [69:0] acc;
        logic [69:0] trial;
        logic [69:0] res;
        acc = '0;
        res = '0;
        for (int i = 33; i >= 0; i--) begin
            acc   = (acc << 2) | 70'(n[2*i +: 2]);
            trial = (res << 2) | 70'd1;
            if (acc >= trial) begin
                acc = acc - trial;
                res = (res << 1) | 70'd1;
            end else begin
                res = res << 1;
            end
        end
        root = res[34:0];
        rest = acc[34:0];
    endfunction

    function automatic contact_t sphere_contact(logic [255:0] d);
        logic signed [32:0] diff;
        logic [31:0]        mag[3];
        logic [31:0]        sh[3];
        logic [2:0]         neg;
        logic [31:0]        mx;
        logic [67:0]        ssum;
        logic [34:0]        root;
        logic [34:0]        rest;
        logic [34:0]        dist_rnd;
        logic [31:0]        rsum;
        logic [63:0]        q;
        contact_t           r;
        mx = '0;
        for (int i = 0; i < 3; i++) begin
            diff = $signed({d[96+32*i+31], d[96+32*i +: 32]})
                 - $signed({d[32*i+31], d[32*i +: 32]});
            neg[i] = diff < 0;
            mag[i] = neg[i] ? 32'(-diff) : 32'(diff);
            if (mag[i] > mx) mx = mag[i];
        end
        ssum = {36'b0, mag[0]} * {36'b0, mag[0]} + {36'b0, mag[1]} * {36'b0, mag[1]}
             + {36'b0, mag[2]} * {36'b0, mag[2]};
        int_sqrt(ssum, root, rest);
        dist_rnd = root + ((rest > root) ? 35'd1 : 35'd0);
        rsum = {1'b0, d[222:192]} + {1'b0, d[253:223]};
        r.sep = dist_rnd - {3'b0, rsum};
        r.coinc = (mx == 0);
        r.nx = '0;
        r.ny = '0;
        r.nz = '0;
        if (mx != 0) begin
            for (int i = 0; i < 3; i++) sh[i] = mag[i];
            while (mx < 32'h8000_0000) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) sh[i] = sh[i] << 1;
            end
            ssum = {36'b0, sh[0]} * {36'b0, sh[0]} + {36'b0, sh[1]} * {36'b0, sh[1]}
                 + {36'b0, sh[2]} * {36'b0, sh[2]};
            int_sqrt(ssum, root, rest);
            for (int i = 0; i < 3; i++) begin
                q = (({32'b0, sh[i]} << 30) + 64'(root >> 1)) / 64'(root);
                if (i == 0) r.nx = neg[i] ? -q[31:0] : q[31:0];
                if (i == 1) r.ny = neg[i] ? -q[31:0] : q[31:0];
                if (i == 2) r.nz = neg[i] ? -q[31:0] : q[31:0];
            end
        end
        return r;
    endfunction

    function automatic logic [255:0] pack_pair(logic [31:0] lx, logic [31:0] ly,
                                               logic [31:0] lz, logic [31:0] rx,
                                               logic [31:0] ry, logic [31:0] rz,
                                               logic [30:0] lr, logic [30:0] rr);
        return {2'b00, rr, lr, rz, ry, rx, lz, ly, lx};
    endfunction

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    task automatic add_pair(logic [255:0] p);
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("error: item %0d %s got %h expected %h", contacts_seen, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n) begin
        logic [255:0] next_pair;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_contacts.insert(expected_contacts.size(), sphere_contact(s_tdata));
                pairs_sent++;
                if (pairs_sent % 64 == 0) calm_send = ($urandom_range(0, 3) == 0);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pairs_sent == 300 && expected_contacts.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    next_pair = pending_pairs.pop_front();
                    s_tdata  <= next_pair;
                    s_tvalid <= 1'b1;
                    send_gap = calm_send ? 0 : $urandom_range(0, 14);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        contact_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_contacts.size() == 0) begin
                    report("unexpected item", m_tdata[63:0], '0);
                end else begin
                    want = expected_contacts.pop_front();
                    if (m_tdata[34:0] !== want.sep)
                        report("separation", 64'(m_tdata[34:0]), 64'(want.sep));
                    if (m_tdata[66:35] !== want.nx)
                        report("normal_x", 64'(m_tdata[66:35]), 64'(want.nx));
                    if (m_tdata[98:67] !== want.ny)
                        report("normal_y", 64'(m_tdata[98:67]), 64'(want.ny));
                    if (m_tdata[130:99] !== want.nz)
                        report("normal_z", 64'(m_tdata[130:99]), 64'(want.nz));
                    if (m_tuser !== want.coinc)
                        report("coincident", 64'(m_tuser), 64'(want.coinc));
                    if (want.coinc) coincident_seen++;
                end
                contacts_seen++;
                if (contacts_seen % 64 == 0) calm_recv = ($urandom_range(0, 3) == 0);
                recv_gap = calm_recv ? 0 : $urandom_range(0, 14);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] lx, ly, lz;
        logic [31:0] off[3];
        int          kind;
        add_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        add_pair(pack_pair(32'h8000_0000, 32'h7fff_ffff, 5, 32'h8000_0000,
                           32'h7fff_ffff, 5, 31'h7fff_ffff, 31'h7fff_ffff));
        add_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0));
        add_pair(pack_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           31'h7fff_ffff, 31'h7fff_ffff));
        add_pair(pack_pair(0, 0, 0, 1, 0, 0, 0, 0));
        add_pair(pack_pair(0, 0, 0, 0, 32'hffff_ffff, 0, 0, 1));
        add_pair(pack_pair(0, 0, 0, 0, 0, 32'h0001_0000, 31'h8000, 31'h8000));
        add_pair(pack_pair(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0));
        add_pair(pack_pair(0, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 0));
        add_pair(pack_pair(0, 0, 0, 3, 4, 0, 31'h1, 31'h2));
        add_pair(pack_pair(0, 0, 0, 1, 1, 1, 0, 0));
        add_pair(pack_pair(0, 0, 0, -32'sd1, -32'sd1, -32'sd1, 0, 0));
        add_pair(pack_pair(10, 20, 30, 10, 20, 31, 31'h7fff_ffff, 0));
        add_pair(pack_pair(0, 0, 0, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0));
        for (int n = 0; n < 750; n++) begin
            kind = $urandom_range(0, 9);
            lx = rnd32();
            ly = rnd32();
            lz = rnd32();
            for (int i = 0; i < 3; i++) begin
                if (kind < 5) off[i] = rnd32();
                else if (kind < 8) off[i] = $signed(rnd32()) >>> $urandom_range(0, 31);
                else if (kind == 8) off[i] = 0;
                else off[i] = (i == n % 3) ? rnd32() >> $urandom_range(0, 31) : 0;
            end
            add_pair({2'($urandom_range(0, 3)), 31'(rnd32()), 31'(rnd32()),
                      32'(lz + off[2]), 32'(ly + off[1]), 32'(lx + off[0]), lz, ly, lx});
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_pairs.size() == 0 && !s_tvalid && expected_contacts.size() == 0);
        repeat (100) @(posedge clk);
        $display("Sent %0d sphere pairs and checked %0d results, %0d of them coincident.",
                 pairs_sent, contacts_seen, coincident_seen);
        if (mismatches == 0 && expected_contacts.size() == 0) begin
            $display("sphere_pair_separation_normal: match");
        end else begin
            $display("sphere_pair_separation_normal: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("sphere_pair_separation_normal: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
